>>> sv/jvwl_pkg.sv
// Shared types and constants of the joint velocity window limiter.
package jvwl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam logic [63:0] STOP_CAP = 64'h4000_0000_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AD_MUL,
    ST_SETUP,
    ST_WINDOW,
    ST_EVAL,
    ST_PATH,
    ST_A_RDIV,
    ST_A_MR,
    ST_A_MU,
    ST_A_NUM,
    ST_A_SDIV,
    ST_A_TR,
    ST_B_T,
    ST_B_P,
    ST_B_DIV,
    ST_JUDGE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_UP_LOW,
    PH_UP_HIGH,
    PH_UP_BIS,
    PH_LO_UP,
    PH_LO_LOW,
    PH_LO_BIS
  } phase_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
    logic [DIV_DEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> sv/jvwl_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module jvwl_div (
  input  logic               clk,
  input  logic               rst,
  input  jvwl_pkg::div_req_t req,
  output jvwl_pkg::div_rsp_t rsp
);

  logic                               running;
  logic                               done;
  logic [jvwl_pkg::DIV_CNT_W-1:0]     count;
  logic [jvwl_pkg::DIV_NUM_W-1:0]     quo;
  logic [jvwl_pkg::DIV_DEN_W-1:0]     rem;
  logic [jvwl_pkg::DIV_DEN_W-1:0]     divisor;
  logic [jvwl_pkg::DIV_DEN_W:0]       rem_shift;
  logic [jvwl_pkg::DIV_DEN_W:0]       diff;
  logic                               take;

  assign rem_shift = {rem, quo[jvwl_pkg::DIV_NUM_W-1]};
  assign diff      = rem_shift - {1'b0, divisor};
  assign take      = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == jvwl_pkg::DIV_CNT_W'(jvwl_pkg::DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (running) begin
      quo <= {quo[jvwl_pkg::DIV_NUM_W-2:0], take};
      rem <= take ? diff[jvwl_pkg::DIV_DEN_W-1:0] : rem_shift[jvwl_pkg::DIV_DEN_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> sv/joint_velocity_window_limiter.sv
// Top level: velocity window search with a shared multiplier and divider.
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  ------------------------
//  command   joint_index .. margin_width              start & !busy
//  config    cfg_data (control_period)                cfg_valid & cfg_ready
//  result    joint_tag, feasible, velocity_low/high   done, one-cycle strobe
//
// An item with a zero acceleration step or an empty window ends without evaluations;
// otherwise each excursion evaluation runs up to two divisions on the shared divider,
// and up to 2 * BISECT_STEPS + 4 evaluations run.
// Reset is synchronous and clears the sequencer and sets control_period to 655.
// busy stays high for the whole item; the result strobe cannot be stalled.
module joint_velocity_window_limiter #(
  parameter int BISECT_STEPS = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         joint_index,
  input  logic signed [31:0] position,
  input  logic signed [31:0] start_velocity,
  input  logic [30:0]        speed_limit,
  input  logic [30:0]        accel_limit,
  input  logic signed [31:0] position_min,
  input  logic signed [31:0] position_max,
  input  logic [30:0]        margin_width,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data,
  output logic               done,
  output logic [5:0]         joint_tag,
  output logic               feasible,
  output logic signed [31:0] velocity_low,
  output logic signed [31:0] velocity_high
);

  localparam int CNT_W = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BISECT_STEPS - 1);

  jvwl_pkg::state_t state, state_next;
  jvwl_pkg::phase_t phase;
  jvwl_pkg::div_req_t div_req;
  jvwl_pkg::div_rsp_t div_rsp;

  logic [16:0]        control_period;
  logic [5:0]         tag;
  logic signed [31:0] q;
  logic signed [31:0] v0;
  logic [30:0]        vlim;
  logic [30:0]        accel;
  logic signed [31:0] pmin;
  logic signed [31:0] pmax;
  logic [30:0]        margin;

  logic [31:0]        ad;
  logic signed [33:0] above;
  logic signed [33:0] below;
  logic signed [31:0] lower;
  logic signed [31:0] upper;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic signed [31:0] mid;
  logic [CNT_W-1:0]   step;
  logic               ok;
  logic signed [32:0] u0;
  logic signed [32:0] u1;
  logic signed [33:0] usum;
  logic [63:0]        acc;
  logic signed [63:0] exc;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  // Window, margins and evaluation operands.
  logic signed [34:0] lower_w, upper_w, neg_vlim, pos_vlim, lower_c, upper_c;
  logic               win_ok;
  logic signed [33:0] q34, pmin_m, pmax_m, qmin_c, qmax_c;
  logic signed [32:0] mid_sum;
  logic signed [31:0] mid_c;
  logic signed [32:0] u0_c, u1_c;
  logic               phase_up;
  logic signed [63:0] bound, travel, stop_s, sum_e;
  logic [63:0]        stop_u;
  logic               exc_gt, exc_gt1, last_step;

  jvwl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy      = (state != jvwl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign neg_vlim = -$signed({4'b0, vlim});
  assign pos_vlim = $signed({4'b0, vlim});
  assign lower_w  = 35'(v0) - $signed({3'b0, ad});
  assign upper_w  = 35'(v0) + $signed({3'b0, ad});
  assign lower_c  = (lower_w < neg_vlim) ? neg_vlim : lower_w;
  assign upper_c  = (upper_w > pos_vlim) ? pos_vlim : upper_w;
  assign win_ok   = (lower_c <= upper_c);

  assign q34    = 34'(q);
  assign pmin_m = 34'(pmin) + $signed({3'b0, margin});
  assign pmax_m = 34'(pmax) - $signed({3'b0, margin});
  assign qmin_c = (q34 < pmin_m) ? q34 : pmin_m;
  assign qmax_c = (q34 > pmax_m) ? q34 : pmax_m;

  assign mid_sum  = 33'(lo) + 33'(hi);
  assign mid_c    = 32'(mid_sum >>> 1);
  assign phase_up = (phase == jvwl_pkg::PH_UP_LOW) || (phase == jvwl_pkg::PH_UP_HIGH) ||
                    (phase == jvwl_pkg::PH_UP_BIS);
  assign u0_c     = phase_up ? 33'(v0) : -33'(v0);

  always_comb begin
    case (phase)
      jvwl_pkg::PH_UP_LOW:  u1_c = 33'(lower);
      jvwl_pkg::PH_UP_HIGH: u1_c = 33'(upper);
      jvwl_pkg::PH_UP_BIS:  u1_c = 33'(mid_c);
      jvwl_pkg::PH_LO_UP:   u1_c = -33'(upper);
      jvwl_pkg::PH_LO_LOW:  u1_c = -33'(lower);
      jvwl_pkg::PH_LO_BIS:  u1_c = -33'(mid_c);
      default:              u1_c = '0;
    endcase
  end

  // Excursion when the end velocity is not negative: travel plus stop distance.
  assign travel = 64'(prod >>> (jvwl_pkg::FRAC_BITS + 1));
  assign stop_u = (div_rsp.quotient > jvwl_pkg::STOP_CAP) ? jvwl_pkg::STOP_CAP
                                                           : div_rsp.quotient;
  assign stop_s = $signed(stop_u);
  assign sum_e  = travel + stop_s;

  assign bound     = phase_up ? 64'(above) : 64'(below);
  assign exc_gt    = (exc > bound);
  assign exc_gt1   = (exc > bound + 64'sd1);
  assign last_step = (step == LAST_STEP);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      jvwl_pkg::ST_IDLE:   if (start) state_next = jvwl_pkg::ST_AD_MUL;
      jvwl_pkg::ST_AD_MUL: state_next = jvwl_pkg::ST_SETUP;
      jvwl_pkg::ST_SETUP:  state_next = jvwl_pkg::ST_WINDOW;
      jvwl_pkg::ST_WINDOW: begin
        if ((ad == '0) || !win_ok) state_next = jvwl_pkg::ST_DONE;
        else state_next = jvwl_pkg::ST_EVAL;
      end
      jvwl_pkg::ST_EVAL:   state_next = jvwl_pkg::ST_PATH;
      jvwl_pkg::ST_PATH: begin
        if (!u1[32]) state_next = jvwl_pkg::ST_A_RDIV;
        else if (u0 > 33'sd0) state_next = jvwl_pkg::ST_B_T;
        else state_next = jvwl_pkg::ST_JUDGE;
      end
      jvwl_pkg::ST_A_RDIV: if (div_rsp.done) state_next = jvwl_pkg::ST_A_MR;
      jvwl_pkg::ST_A_MR:   state_next = jvwl_pkg::ST_A_MU;
      jvwl_pkg::ST_A_MU:   state_next = jvwl_pkg::ST_A_NUM;
      jvwl_pkg::ST_A_NUM:  state_next = jvwl_pkg::ST_A_SDIV;
      jvwl_pkg::ST_A_SDIV: if (div_rsp.done) state_next = jvwl_pkg::ST_A_TR;
      jvwl_pkg::ST_A_TR:   state_next = jvwl_pkg::ST_JUDGE;
      jvwl_pkg::ST_B_T:    state_next = jvwl_pkg::ST_B_P;
      jvwl_pkg::ST_B_P:    state_next = jvwl_pkg::ST_B_DIV;
      jvwl_pkg::ST_B_DIV:  if (div_rsp.done) state_next = jvwl_pkg::ST_JUDGE;
      jvwl_pkg::ST_JUDGE: begin
        case (phase)
          jvwl_pkg::PH_UP_LOW, jvwl_pkg::PH_LO_UP:
            state_next = exc_gt1 ? jvwl_pkg::ST_DONE : jvwl_pkg::ST_EVAL;
          jvwl_pkg::PH_LO_LOW:
            state_next = exc_gt ? jvwl_pkg::ST_EVAL : jvwl_pkg::ST_DONE;
          jvwl_pkg::PH_LO_BIS:
            state_next = last_step ? jvwl_pkg::ST_DONE : jvwl_pkg::ST_EVAL;
          default:
            state_next = jvwl_pkg::ST_EVAL;
        endcase
      end
      jvwl_pkg::ST_DONE:   state_next = jvwl_pkg::ST_IDLE;
      default:             state_next = jvwl_pkg::ST_IDLE;
    endcase
  end

  // Operands of the shared multiplier and divider.
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      jvwl_pkg::ST_AD_MUL: begin
        mul_a = $signed({3'b0, accel});
        mul_b = $signed({17'b0, control_period});
      end
      jvwl_pkg::ST_PATH: begin
        mul_a            = $signed({17'b0, control_period});
        mul_b            = 34'(u0);
        div_req.start    = !u1[32];
        div_req.dividend = {31'b0, u1};
        div_req.divisor  = {2'b0, ad};
      end
      jvwl_pkg::ST_A_MR: begin
        mul_a = $signed(div_rsp.remainder);
        mul_b = $signed({2'b0, ad} - div_rsp.remainder);
      end
      jvwl_pkg::ST_A_MU: begin
        mul_a = 34'(u1);
        mul_b = 34'(u1);
      end
      jvwl_pkg::ST_A_NUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc + prod[63:0];
        div_req.divisor  = {2'b0, accel, 1'b0};
      end
      jvwl_pkg::ST_A_SDIV: begin
        mul_a = $signed({17'b0, control_period});
        mul_b = usum;
      end
      jvwl_pkg::ST_B_T: begin
        mul_a = 34'(prod >>> jvwl_pkg::FRAC_BITS);
        mul_b = 34'(u0);
      end
      jvwl_pkg::ST_B_P: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[63:0];
        div_req.divisor  = $unsigned(34'(u0) - 34'(u1));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= jvwl_pkg::ST_IDLE;
      control_period <= 17'd655;
      done           <= 1'b0;
      phase          <= jvwl_pkg::PH_UP_LOW;
      step           <= '0;
      ok             <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == jvwl_pkg::ST_DONE);
      if (cfg_valid && cfg_ready) control_period <= cfg_data;
      case (state)
        jvwl_pkg::ST_WINDOW: begin
          ok    <= (ad != '0) && win_ok;
          phase <= jvwl_pkg::PH_UP_LOW;
        end
        jvwl_pkg::ST_JUDGE: begin
          case (phase)
            jvwl_pkg::PH_UP_LOW: begin
              if (exc_gt1) ok <= 1'b0;
              else phase <= jvwl_pkg::PH_UP_HIGH;
            end
            jvwl_pkg::PH_UP_HIGH: begin
              step  <= '0;
              phase <= exc_gt ? jvwl_pkg::PH_UP_BIS : jvwl_pkg::PH_LO_UP;
            end
            jvwl_pkg::PH_UP_BIS: begin
              step <= step + 1'b1;
              if (last_step) phase <= jvwl_pkg::PH_LO_UP;
            end
            jvwl_pkg::PH_LO_UP: begin
              if (exc_gt1) ok <= 1'b0;
              else phase <= jvwl_pkg::PH_LO_LOW;
            end
            jvwl_pkg::PH_LO_LOW: begin
              step <= '0;
              if (exc_gt) phase <= jvwl_pkg::PH_LO_BIS;
            end
            jvwl_pkg::PH_LO_BIS: step <= step + 1'b1;
            default: phase <= jvwl_pkg::PH_UP_LOW;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Item payload and working values.
  always_ff @(posedge clk) begin
    case (state)
      jvwl_pkg::ST_IDLE: begin
        if (start) begin
          tag    <= joint_index;
          q      <= position;
          v0     <= start_velocity;
          vlim   <= speed_limit;
          accel  <= accel_limit;
          pmin   <= position_min;
          pmax   <= position_max;
          margin <= margin_width;
        end
      end
      jvwl_pkg::ST_SETUP: begin
        ad    <= 32'(prod >>> jvwl_pkg::FRAC_BITS);
        below <= q34 - qmin_c;
        above <= qmax_c - q34;
      end
      jvwl_pkg::ST_WINDOW: begin
        lower <= 32'(lower_c);
        upper <= 32'(upper_c);
      end
      jvwl_pkg::ST_EVAL: begin
        u0  <= u0_c;
        u1  <= u1_c;
        mid <= mid_c;
      end
      jvwl_pkg::ST_PATH: exc <= '0;
      jvwl_pkg::ST_A_MU: acc <= prod[63:0];
      jvwl_pkg::ST_A_NUM: usum <= 34'(u0) + 34'(u1);
      jvwl_pkg::ST_A_TR: exc <= sum_e[63] ? 64'sd0 : sum_e;
      jvwl_pkg::ST_B_DIV: begin
        if (div_rsp.done) exc <= $signed({1'b0, div_rsp.quotient[63:1]});
      end
      jvwl_pkg::ST_JUDGE: begin
        case (phase)
          jvwl_pkg::PH_UP_HIGH, jvwl_pkg::PH_LO_LOW: begin
            lo <= lower;
            hi <= upper;
          end
          jvwl_pkg::PH_UP_BIS: begin
            // A midpoint that still stops in time becomes the new low end.
            if (!exc_gt) lo <= mid;
            else hi <= mid;
            if (last_step) upper <= exc_gt ? lo : mid;
          end
          jvwl_pkg::PH_LO_BIS: begin
            if (!exc_gt) hi <= mid;
            else lo <= mid;
            if (last_step) lower <= exc_gt ? hi : mid;
          end
          default: ;
        endcase
      end
      jvwl_pkg::ST_DONE: begin
        joint_tag     <= tag;
        feasible      <= ok && (lower <= upper);
        velocity_low  <= (ok && (lower <= upper)) ? lower : 32'sd0;
        velocity_high <= (ok && (lower <= upper)) ? upper : 32'sd0;
      end
      default: ;
    endcase
  end

endmodule
